>>> src/tsr_pkg.sv
// Shared types and constants for the triangle scan rasterizer.
package tsr_pkg;

    localparam int COORD_BITS = 12;
    localparam int VTX_W   = 16;
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 12;
    localparam int ADDR_W  = 24;
    localparam int DIN_W   = 24;
    localparam int COLOR_W = 8;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    localparam logic [1:0] SEL_V0     = 2'd0;
    localparam logic [1:0] SEL_V2     = 2'd2;
    localparam logic [1:0] SEL_UNUSED = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // One classified pixel handed from the scan front to the shading back end.
    typedef struct packed {
        logic              idle;
        logic              last;
        logic [PIX_W-1:0]  x;
        logic [PIX_W-1:0]  y;
    } t_pix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_DIV,
        ST_OUT
    } t_bstate;

endpackage

>>> src/tsr_front.sv
// Scan front end: vertex storage, bounding box setup and pixel walk.
module tsr_front #(
    parameter int DEPTH_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_op,
    input  logic [1:0]                 i_vertex_sel,
    input  logic signed [15:0]         i_vertex_x,
    input  logic signed [15:0]         i_vertex_y,
    input  logic [23:0]                i_vertex_depth,
    input  logic [7:0]                 i_color_red,
    input  logic [7:0]                 i_color_green,
    input  logic [7:0]                 i_color_blue,
    input  logic [tsr_pkg::DIM_W-1:0]  i_width,
    input  logic [tsr_pkg::DIM_W-1:0]  i_height,
    input  logic                       i_drained,
    input  logic                       i_q_ready,
    output logic                       o_q_valid,
    output tsr_pkg::t_pix              o_q_pix,
    output logic signed [15:0]         o_cx [3],
    output logic signed [15:0]         o_cy [3],
    output logic [DEPTH_BITS-1:0]      o_cd [3],
    output logic [23:0]                o_color
);
    import tsr_pkg::*;

    localparam int CB = COORD_BITS;

    logic signed [15:0]    r_cx [3];
    logic signed [15:0]    r_cy [3];
    logic [DEPTH_BITS-1:0] r_cd [3];
    logic [23:0]           r_color;
    logic [CB-1:0]         r_xmax, r_ymin, r_ymax, r_col, r_row;
    logic                  r_busy;

    logic signed [15:0] nx [3];
    logic signed [15:0] ny [3];
    logic signed [15:0] lx, hx, ly, hy;
    logic signed [13:0] flx, fhx, fly, fhy;
    logic [DIM_W-1:0]   ew, eh;
    logic signed [14:0] cx0, cx1, cy0, cy1;
    logic               nonempty, take, is_load, is_last, end_row;

    function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] r);
        logic [DIM_W:0] lim;
        lim = (DIM_W+1)'(1) << CB;
        if (r == '0) return DIM_W'(1);
        if ({1'b0, r} > lim) return lim[DIM_W-1:0];
        return r;
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nx[i] = r_cx[i];
            ny[i] = r_cy[i];
        end
        nx[2] = i_vertex_x;
        ny[2] = i_vertex_y;
        lx = nx[0]; hx = nx[0]; ly = ny[0]; hy = ny[0];
        for (int i = 1; i < 3; i++) begin
            if (nx[i] < lx) lx = nx[i];
            if (nx[i] > hx) hx = nx[i];
            if (ny[i] < ly) ly = ny[i];
            if (ny[i] > hy) hy = ny[i];
        end
        flx = 14'(lx >>> 4);
        fhx = 14'(hx >>> 4);
        fly = 14'(ly >>> 4);
        fhy = 14'(hy >>> 4);
        ew = eff(i_width);
        eh = eff(i_height);
        cx0 = (flx < 0) ? 15'sd0 : 15'(flx);
        cy0 = (fly < 0) ? 15'sd0 : 15'(fly);
        cx1 = (15'(fhx) > $signed({2'b0, ew}) - 15'sd1) ? $signed({2'b0, ew}) - 15'sd1
                                                        : 15'(fhx);
        cy1 = (15'(fhy) > $signed({2'b0, eh}) - 15'sd1) ? $signed({2'b0, eh}) - 15'sd1
                                                        : 15'(fhy);
        nonempty = (cx0 <= cx1) && (cy0 <= cy1);
    end

    // The back end reads the vertex and color registers directly, so a load waits
    // until every earlier step transaction has left the block.
    assign is_load = (t_op'(i_op) == OP_LOAD);
    assign o_ready = is_load ? i_drained : i_q_ready;
    assign take    = i_valid && o_ready;
    assign end_row = (r_row == r_ymax);
    assign is_last = (r_col == r_xmax) && end_row;

    assign o_q_valid    = i_valid && !is_load;
    assign o_q_pix.idle = !r_busy;
    assign o_q_pix.last = !r_busy || is_last;
    assign o_q_pix.x    = r_busy ? PIX_W'(r_col) : '0;
    assign o_q_pix.y    = r_busy ? PIX_W'(r_row) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
                r_cd[i] <= '0;
            end
            r_color <= '0;
            r_xmax  <= '0;
            r_ymin  <= '0;
            r_ymax  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_busy  <= 1'b0;
        end else if (take) begin
            if (is_load) begin
                if (i_vertex_sel != SEL_UNUSED) begin
                    r_cx[i_vertex_sel] <= i_vertex_x;
                    r_cy[i_vertex_sel] <= i_vertex_y;
                    r_cd[i_vertex_sel] <= DEPTH_BITS'(i_vertex_depth);
                end
                if (i_vertex_sel == SEL_V0) begin
                    r_color <= {i_color_red, i_color_green, i_color_blue};
                end
                if (i_vertex_sel == SEL_V2) begin
                    r_busy <= nonempty;
                    if (nonempty) begin
                        r_xmax <= CB'(cx1);
                        r_ymin <= CB'(cy0);
                        r_ymax <= CB'(cy1);
                        r_col  <= CB'(cx0);
                        r_row  <= CB'(cy0);
                    end else begin
                        r_xmax <= '0;
                        r_ymin <= '0;
                        r_ymax <= '0;
                    end
                end
            end else if (r_busy) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else if (end_row) begin
                    r_row <= r_ymin;
                    r_col <= r_col + CB'(1);
                end else begin
                    r_row <= r_row + CB'(1);
                end
            end
        end
    end

    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_cd    = r_cd;
    assign o_color = r_color;

endmodule

>>> src/tsr_queue.sv
// Two-entry queue between the scan front and the shading back end.
module tsr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tsr_pkg::t_pix  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tsr_pkg::t_pix  o_data
);
    import tsr_pkg::*;

    t_pix       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> src/tsr_back.sv
// Shading back end: edge tests, serial depth division and result register.
module tsr_back #(
    parameter int DEPTH_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  tsr_pkg::t_pix              i_pix,
    input  logic signed [15:0]         i_cx [3],
    input  logic signed [15:0]         i_cy [3],
    input  logic [DEPTH_BITS-1:0]      i_cd [3],
    input  logic [23:0]                i_color,
    input  logic [tsr_pkg::DIM_W-1:0]  i_width,
    input  logic [tsr_pkg::DIM_W-1:0]  i_height,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_covered,
    output logic [11:0]                o_pixel_x,
    output logic [11:0]                o_pixel_y,
    output logic [23:0]                o_pixel_depth,
    output logic [23:0]                o_frame_address,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue,
    output logic                       o_last_pixel
);
    import tsr_pkg::*;

    // Edge values fit in 36 bits; the weighted sum needs DEPTH_BITS more plus two.
    localparam int EW = 36;
    localparam int SW = EW + DEPTH_BITS + 2;
    localparam int CW = $clog2(SW + 1);

    t_bstate          r_st, n_st;
    t_pix             r_pix;
    logic signed [EW-1:0] r_e [3];
    logic [EW-1:0]    r_w [3];
    logic [1:0]       r_k;
    logic [SW-1:0]    r_sum, r_quo;
    logic [EW:0]      r_rem;
    logic [EW-1:0]    r_area;
    logic [CW-1:0]    r_cnt;
    logic             r_cov;
    logic [23:0]      r_addr;

    logic signed [17:0] px, py;
    logic signed [EW-1:0] ec [3];
    logic pos, neg;
    logic [EW:0] rem_sh;
    logic [EW+DEPTH_BITS-1:0] prod;
    logic [1:0] dk, wk;
    logic [DIM_W-1:0] ew, eh;
    logic [ADDR_W-1:0] rowf;

    function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] r);
        logic [DIM_W:0] lim;
        lim = (DIM_W+1)'(1) << COORD_BITS;
        if (r == '0) return DIM_W'(1);
        if ({1'b0, r} > lim) return lim[DIM_W-1:0];
        return r;
    endfunction

    always_comb begin
        px = $signed({2'b0, i_pix.x, 4'b0});
        py = $signed({2'b0, i_pix.y, 4'b0});
        for (int i = 0; i < 3; i++) begin
            ec[i] = EW'((18'(i_cx[(i+1)%3]) - 18'(i_cx[i])) * (py - 18'(i_cy[i])))
                  - EW'((18'(i_cy[(i+1)%3]) - 18'(i_cy[i])) * (px - 18'(i_cx[i])));
        end
        ew   = eff(i_width);
        eh   = eff(i_height);
        // A row at or above the height wraps in the address.
        rowf = ADDR_W'(eh) - ADDR_W'(1) - ADDR_W'(i_pix.y);
    end

    // Vertex k is weighted by the edge opposite it.
    always_comb begin
        dk = (r_k == 2'd3) ? 2'd0 : r_k;
        wk = (dk == 2'd2) ? 2'd0 : dk + 2'd1;
    end

    assign pos = (r_e[0] > 0) && (r_e[1] > 0) && (r_e[2] > 0);
    assign neg = (r_e[0] < 0) && (r_e[1] < 0) && (r_e[2] < 0);
    assign prod = r_w[wk] * i_cd[dk];
    assign rem_sh = {r_rem[EW-1:0], r_sum[SW-1]};

    assign o_ready = (r_st == ST_IDLE);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_valid) n_st = i_pix.idle ? ST_OUT : ST_EDGE;
            ST_EDGE: n_st = (pos || neg) ? ST_DIV : ST_OUT;
            ST_DIV:  if (r_k == 2'd3 && r_cnt == '0) n_st = ST_OUT;
            ST_OUT:  if (i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: if (i_valid) begin
                r_pix  <= i_pix;
                r_e    <= ec;
                r_cov  <= 1'b0;
                r_addr <= 24'(rowf * ew) + 24'(i_pix.x);
            end
            ST_EDGE: begin
                r_cov <= pos || neg;
                for (int i = 0; i < 3; i++) r_w[i] <= neg ? EW'(-r_e[i]) : EW'(r_e[i]);
                r_area <= neg ? EW'(-r_e[0] - r_e[1] - r_e[2]) : EW'(r_e[0] + r_e[1] + r_e[2]);
                r_k   <= 2'd0;
                r_sum <= '0;
                r_quo <= '0;
                r_rem <= '0;
                r_cnt <= CW'(SW);
            end
            ST_DIV: begin
                // The weighted sum is accumulated over the three vertices, then one quotient bit a cycle.
                if (r_k != 2'd3) begin
                    r_sum <= r_sum + SW'(prod);
                    r_k   <= r_k + 2'd1;
                end else if (r_cnt != '0) begin
                    r_sum <= r_sum << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (rem_sh >= {1'b0, r_area}) begin
                        r_rem <= rem_sh - {1'b0, r_area};
                        r_quo <= {r_quo[SW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[SW-2:0], 1'b0};
                    end
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    assign o_valid         = (r_st == ST_OUT);
    assign o_covered       = r_cov;
    assign o_pixel_x       = r_pix.x;
    assign o_pixel_y       = r_pix.y;
    assign o_pixel_depth   = r_cov ? 24'(r_quo) : '0;
    assign o_frame_address = r_pix.idle ? '0 : r_addr;
    assign o_out_red       = r_pix.idle ? '0 : i_color[23:16];
    assign o_out_green     = r_pix.idle ? '0 : i_color[15:8];
    assign o_out_blue      = r_pix.idle ? '0 : i_color[7:0];
    assign o_last_pixel    = r_pix.last;

endmodule

>>> src/triangle_scan_rasterizer.sv
// Top level of the triangle scan rasterizer.
// Load transactions return no result; a load is accepted only once every earlier step
// transaction has left the block, because the back end reads the vertex, color and screen
// registers directly. A step transaction is classified by the scan front and queued two
// deep. The back end then passes an idle step through its idle and output states, a pixel
// outside the triangle through its idle, edge and output states, and a covered one also
// through the bit-serial divider that forms the interpolated depth from the 62-bit
// weighted sum (with the default DEPTH_BITS). The screen registers must be written only
// while the block is idle; the block itself does not enforce this.
module triangle_scan_rasterizer #(
    parameter int DEPTH_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [12:0]                i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_op,
    input  logic [1:0]                 i_vertex_sel,
    input  logic signed [15:0]         i_vertex_x,
    input  logic signed [15:0]         i_vertex_y,
    input  logic [23:0]                i_vertex_depth,
    input  logic [7:0]                 i_color_red,
    input  logic [7:0]                 i_color_green,
    input  logic [7:0]                 i_color_blue,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_covered,
    output logic [11:0]                o_pixel_x,
    output logic [11:0]                o_pixel_y,
    output logic [23:0]                o_pixel_depth,
    output logic [23:0]                o_frame_address,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue,
    output logic                       o_last_pixel
);
    import tsr_pkg::*;

    logic [DIM_W-1:0]      r_width, r_height;
    logic                  fq_valid, fq_ready, qb_valid, qb_ready;
    logic                  drained;
    t_pix                  fq_pix, qb_pix;
    logic signed [15:0]    cx [3];
    logic signed [15:0]    cy [3];
    logic [DEPTH_BITS-1:0] cd [3];
    logic [23:0]           color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH)  r_width  <= i_cfg_data;
            if (i_cfg_index == REG_HEIGHT) r_height <= i_cfg_data;
        end
    end

    assign drained = !qb_valid && qb_ready;

    tsr_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .i_vertex_sel, .i_vertex_x,
        .i_vertex_y, .i_vertex_depth, .i_color_red, .i_color_green, .i_color_blue,
        .i_width(r_width), .i_height(r_height), .i_drained(drained),
        .i_q_ready(fq_ready), .o_q_valid(fq_valid), .o_q_pix(fq_pix),
        .o_cx(cx), .o_cy(cy), .o_cd(cd), .o_color(color)
    );

    tsr_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(fq_valid), .o_ready(fq_ready), .i_data(fq_pix),
        .o_valid(qb_valid), .i_ready(qb_ready), .o_data(qb_pix)
    );

    tsr_back #(.DEPTH_BITS(DEPTH_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(qb_valid), .o_ready(qb_ready), .i_pix(qb_pix),
        .i_cx(cx), .i_cy(cy), .i_cd(cd), .i_color(color),
        .i_width(r_width), .i_height(r_height),
        .o_valid, .i_ready, .o_covered, .o_pixel_x, .o_pixel_y, .o_pixel_depth,
        .o_frame_address, .o_out_red, .o_out_green, .o_out_blue, .o_last_pixel
    );

endmodule

>>> verif/triangle_scan_rasterizer_tb.sv
// Self-checking testbench for the triangle scan rasterizer.
module triangle_scan_rasterizer_tb;
    import tsr_pkg::*;

    typedef struct packed {
        t_op                op;
        logic [1:0]         sel;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [23:0]        vdepth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_raster_cmd;

    typedef struct packed {
        logic        covered;
        logic [11:0] px;
        logic [11:0] py;
        logic [23:0] depth;
        logic [23:0] addr;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } t_pixel_out;

    localparam int CMD_W = $bits(t_raster_cmd);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [1:0]  i_vertex_sel;
    logic signed [15:0] i_vertex_x;
    logic signed [15:0] i_vertex_y;
    logic [23:0] i_vertex_depth;
    logic [7:0]  i_color_red;
    logic [7:0]  i_color_green;
    logic [7:0]  i_color_blue;
    logic        o_valid;
    logic        i_ready;
    logic        o_covered;
    logic [11:0] o_pixel_x;
    logic [11:0] o_pixel_y;
    logic [23:0] o_pixel_depth;
    logic [23:0] o_frame_address;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        o_last_pixel;

    triangle_scan_rasterizer dut (.*);

    // Predictor state.
    longint      vtx_x [3];
    longint      vtx_y [3];
    bit [63:0]   vtx_depth [3];
    bit [23:0]   tri_color;
    bit [11:0]   box_x0, box_x1, box_y0, box_y1;
    bit [11:0]   cur_col, cur_row;
    bit          scanning;
    bit [12:0]   scr_width, scr_height;

    t_pixel_out  pending_pixels[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;
    int          hold_left;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clip_dim(bit [12:0] r);
        if (r == 0) return 1;
        if (r > 4096) return 4096;
        return r;
    endfunction

    // Divides the weighted depth sum by the twice-area, truncating.
    function automatic bit [63:0] blend_depth(bit [63:0] w0, bit [63:0] w1, bit [63:0] w2);
        bit [63:0] area, shi, slo, qh, rh, ql;
        area = w0 + w1 + w2;
        shi = w0 * (vtx_depth[0] >> 16) + w1 * (vtx_depth[1] >> 16)
            + w2 * (vtx_depth[2] >> 16);
        slo = w0 * (vtx_depth[0] & 64'hFFFF) + w1 * (vtx_depth[1] & 64'hFFFF)
            + w2 * (vtx_depth[2] & 64'hFFFF);
        qh = shi / area;
        rh = shi % area;
        ql = ((rh << 16) + slo) / area;
        return (qh << 16) + ql;
    endfunction

    function automatic longint edge_fn(int a, int b, longint qx, longint qy);
        return (vtx_x[b] - vtx_x[a]) * (qy - vtx_y[a])
             - (vtx_y[b] - vtx_y[a]) * (qx - vtx_x[a]);
    endfunction

    function automatic void setup_box();
        longint lx, hx, ly, hy;
        lx = vtx_x[0]; hx = vtx_x[0]; ly = vtx_y[0]; hy = vtx_y[0];
        for (int i = 1; i < 3; i++) begin
            if (vtx_x[i] < lx) lx = vtx_x[i];
            if (vtx_x[i] > hx) hx = vtx_x[i];
            if (vtx_y[i] < ly) ly = vtx_y[i];
            if (vtx_y[i] > hy) hy = vtx_y[i];
        end
        lx = lx >>> 4; hx = hx >>> 4; ly = ly >>> 4; hy = hy >>> 4;
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (hx > clip_dim(scr_width) - 1) hx = clip_dim(scr_width) - 1;
        if (hy > clip_dim(scr_height) - 1) hy = clip_dim(scr_height) - 1;
        if (lx > hx || ly > hy) begin
            scanning = 1'b0;
            box_x0 = 0; box_x1 = 0; box_y0 = 0; box_y1 = 0;
            return;
        end
        box_x0 = 12'(lx); box_x1 = 12'(hx); box_y0 = 12'(ly); box_y1 = 12'(hy);
        cur_col = 12'(lx);
        cur_row = 12'(ly);
        scanning = 1'b1;
    endfunction

    // Applies one accepted transaction; returns 1 when it yields a pixel.
    function automatic bit rasterize_cmd(t_raster_cmd c, output t_pixel_out r);
        longint e0, e1, e2;
        bit [63:0] addr;
        bit hit;
        r = '0;
        hit = 1'b0;
        if (c.op == OP_LOAD) begin
            if (c.sel == SEL_UNUSED) return 0;
            vtx_x[c.sel] = longint'(c.vx);
            vtx_y[c.sel] = longint'(c.vy);
            vtx_depth[c.sel] = 64'(c.vdepth);
            if (c.sel == SEL_V0) tri_color = {c.red, c.green, c.blue};
            if (c.sel == SEL_V2) setup_box();
            return 0;
        end
        if (!scanning) begin
            r.last = 1'b1;
            return 1;
        end
        e0 = edge_fn(0, 1, cur_col * 16, cur_row * 16);
        e1 = edge_fn(1, 2, cur_col * 16, cur_row * 16);
        e2 = edge_fn(2, 0, cur_col * 16, cur_row * 16);
        if (e0 > 0 && e1 > 0 && e2 > 0) hit = 1'b1;
        if (e0 < 0 && e1 < 0 && e2 < 0) begin
            hit = 1'b1;
            e0 = -e0; e1 = -e1; e2 = -e2;
        end
        if (hit) r.depth = 24'(blend_depth(e1, e2, e0));
        addr = (64'(clip_dim(scr_height)) - 1 - cur_row) * 64'(clip_dim(scr_width)) + cur_col;
        r.covered = hit;
        r.px = cur_col;
        r.py = cur_row;
        r.addr = addr[23:0];
        {r.red, r.green, r.blue} = tri_color;
        r.last = (cur_col == box_x1) && (cur_row == box_y1);
        if (r.last) begin
            scanning = 1'b0;
        end else if (cur_row == box_y1) begin
            cur_row = box_y0;
            cur_col = cur_col + 12'd1;
        end else begin
            cur_row = cur_row + 12'd1;
        end
        return 1;
    endfunction

    // Result side: random or held-off ready.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_out got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_covered, o_pixel_x, o_pixel_y, o_pixel_depth, o_frame_address,
                   o_out_red, o_out_green, o_out_blue, o_last_pixel};
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel cov=%0d x=%0d y=%0d", $time,
                         got.covered, got.px, got.py);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (got != want) begin
                    $display("%0t: pixel mismatch expected cov=%0d x=%0d y=%0d z=%h a=%h rgb=%h%h%h last=%0d",
                             $time, want.covered, want.px, want.py, want.depth, want.addr,
                             want.red, want.green, want.blue, want.last);
                    $display("%0t:                  actual cov=%0d x=%0d y=%0d z=%h a=%h rgb=%h%h%h last=%0d",
                             $time, got.covered, got.px, got.py, got.depth, got.addr,
                             got.red, got.green, got.blue, got.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("triangle_scan_rasterizer_tb: errors");
            $finish;
        end
    end

    task automatic send_cmd(t_raster_cmd c);
        t_pixel_out r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_op           <= c.op;
        i_vertex_sel   <= c.sel;
        i_vertex_x     <= c.vx;
        i_vertex_y     <= c.vy;
        i_vertex_depth <= c.vdepth;
        i_color_red    <= c.red;
        i_color_green  <= c.green;
        i_color_blue   <= c.blue;
        do @(posedge i_clk); while (!o_ready);
        if (rasterize_cmd(c, r)) pending_pixels.push_back(r);
    endtask

    task automatic load_vertex(logic [1:0] sel, int x, int y, logic [23:0] z);
        t_raster_cmd c;
        c.op = OP_LOAD;
        c.sel = sel;
        c.vx = 16'(x);
        c.vy = 16'(y);
        c.vdepth = z;
        c.red = 8'($urandom);
        c.green = 8'($urandom);
        c.blue = 8'($urandom);
        send_cmd(c);
    endtask

    task automatic step_pixels(int n);
        t_raster_cmd c;
        c = '0;
        c.op = OP_STEP;
        for (int i = 0; i < n; i++) begin
            c.sel = 2'($urandom);
            c.vx = 16'($urandom);
            send_cmd(c);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // A load leaves no result behind; once no pixel is pending, every step result has been taken.
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_screen(logic [12:0] w, logic [12:0] h);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        scr_width = w;
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        scr_height = h;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        t_raster_cmd c;
        step_pixels(2);
        c = '0;
        c.op = OP_LOAD;
        c.sel = SEL_UNUSED;
        c.vx = 16'sh7FFF;
        c.vy = -16'sh8000;
        c.vdepth = 24'hFFFFFF;
        c.red = 8'hFF; c.green = 8'hFF; c.blue = 8'hFF;
        send_cmd(c);
        step_pixels(1);
        // Counter-clockwise triangle at maximum depth.
        load_vertex(0, 8, 8, 24'hFFFFFF);
        load_vertex(1, 88, 8, 24'hFFFFFF);
        load_vertex(2, 8, 88, 24'hFFFFFF);
        step_pixels(8);
        // Clockwise winding, with vertex 0 reloaded partway through the scan.
        load_vertex(0, 8, 8, 24'h000000);
        load_vertex(1, 8, 72, 24'h123456);
        load_vertex(2, 72, 8, 24'hFFFFFF);
        step_pixels(10);
        load_vertex(0, 0, 0, 24'h800000);
        step_pixels(17);
        // Zero-area triangle.
        load_vertex(1, 48, 48, 0);
        load_vertex(2, 24, 24, 0);
        step_pixels(5);
        // Box entirely off screen.
        load_vertex(0, -32768, -32768, 0);
        load_vertex(1, -16, -32768, 0);
        load_vertex(2, -32768, -16, 0);
        step_pixels(1);
        // Field extremes: box clipped to the whole screen.
        load_vertex(1, 32767, 32767, 24'hFFFFFF);
        load_vertex(2, 32767, -32768, 24'h000001);
        step_pixels(4);
    endtask

    task automatic random_triangle();
        int base_x, base_y, spread;
        base_x = $urandom_range(0, 9) == 0 ? int'(clip_dim(scr_width) - 3)
                                           : int'($urandom_range(0, 40)) - 2;
        base_y = $urandom_range(0, 9) == 0 ? int'(clip_dim(scr_height) - 3)
                                           : int'($urandom_range(0, 40)) - 2;
        spread = $urandom_range(0, 4);
        for (int v = 0; v < 3; v++)
            load_vertex(2'(v), (base_x + $urandom_range(0, spread)) * 16 + $urandom_range(0, 15),
                        (base_y + $urandom_range(0, spread)) * 16 + $urandom_range(0, 15),
                        24'($urandom));
        step_pixels($urandom_range(1, (spread + 2) * (spread + 2) + 2));
    endtask

    task automatic test_random(int n);
        int start_items;
        t_raster_cmd c;
        start_items = 0;
        while (start_items < n) begin
            if ($urandom_range(0, 9) == 0) begin
                c = t_raster_cmd'(CMD_W'({$urandom, $urandom, $urandom}));
                c.op = t_op'($urandom_range(0, 1));
                send_cmd(c);
                start_items++;
            end else begin
                random_triangle();
                start_items += 13;
            end
        end
    endtask

    task automatic test_backpressure();
        load_vertex(0, 0, 0, 24'h00FFFF);
        load_vertex(1, 160, 16, 24'hABCDEF);
        load_vertex(2, 16, 160, 24'h7F0000);
        hold_request = 400;
        step_pixels(40);
        // Sender waits for every pixel before going on.
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        step_pixels(20);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_op = OP_LOAD;
        i_vertex_sel = '0;
        i_vertex_x = '0;
        i_vertex_y = '0;
        i_vertex_depth = '0;
        i_color_red = '0;
        i_color_green = '0;
        i_color_blue = '0;
        error_count = 0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        send_idle_pct = 33;
        recv_idle_pct = 60;
        for (int i = 0; i < 3; i++) begin
            vtx_x[i] = 0; vtx_y[i] = 0; vtx_depth[i] = 0;
        end
        tri_color = 0;
        box_x0 = 0; box_x1 = 0; box_y0 = 0; box_y1 = 0;
        cur_col = 0; cur_row = 0;
        scanning = 1'b0;
        scr_width = 1024;
        scr_height = 1024;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);
        write_screen(1, 1);
        test_random(150);
        send_idle_pct = 60;
        recv_idle_pct = 33;
        write_screen(0, 8191);
        test_random(300);
        write_screen(4096, 4096);
        test_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_screen(13, 7);
        test_backpressure();
        test_random(300);
        write_screen(8191, 0);
        test_random(150);
        write_screen(1024, 1024);
        test_random(200);

        drain();
        if (error_count == 0) begin
            $display("triangle_scan_rasterizer_tb: clean");
        end else begin
            $display("triangle_scan_rasterizer_tb: errors");
        end
        $finish;
    end

endmodule
